// ===== rtl/psched_pkg.sv =====
// Package for the preemptive priority scheduler.
// Holds the slot count, the field widths, the request opcodes and the derived index width.
// No dependencies.
package psched_pkg;

  localparam int NUM_SLOTS = 3;
  localparam int SLOT_W    = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;

  localparam int TICK_W = 16;
  localparam int DUR_W  = 10;
  localparam int PRI_W  = 7;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

endpackage

// ===== rtl/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler: slot table, shared compare unit, sequencer.
// Uses psched_pkg for the slot count and widths.
// A load request is taken whenever the sequencer is idle. A tick request runs a scan state
// (one compare per slot), then an update state that holds while the result is stalled and
// then writes the result registers. No new request is taken until the sequencer is back in
// idle; loads leave it idle and go back to back. Reset (rst, synchronous) clears the tick
// counter and every slot's remaining work; other slot fields are written by loads.
module preemptive_priority_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [1:0]                    slot,
  input  logic [psched_pkg::DUR_W-1:0]  duration,
  input  logic [psched_pkg::PRI_W-1:0]  priority_req,
  input  logic [psched_pkg::TICK_W-1:0] arrival,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [psched_pkg::TICK_W-1:0] tick_now,
  output logic [1:0]                    running_slot,
  output logic                          idle,
  output logic [2:0]                    waiting_mask,
  output logic [psched_pkg::DUR_W-1:0]  remaining_left,
  output logic                          all_done
);

  localparam int N  = psched_pkg::NUM_SLOTS;
  localparam int SW = psched_pkg::SLOT_W;

  // sequencer codes
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state;

  // slot table; only remaining work has a reset value
  logic [psched_pkg::DUR_W-1:0]  slot_duration  [N];
  logic [psched_pkg::PRI_W-1:0]  slot_priority  [N];
  logic [psched_pkg::TICK_W-1:0] slot_arrival   [N];
  logic [psched_pkg::DUR_W-1:0]  slot_remaining [N];

  logic [psched_pkg::TICK_W-1:0] elapsed_ticks;

  // scan bookkeeping
  logic [SW-1:0]                scan_idx;
  logic                         found;
  logic [SW-1:0]                best_idx;
  logic [psched_pkg::PRI_W-1:0] best_pri;
  logic [psched_pkg::DUR_W-1:0] best_dur;
  logic [N-1:0]                 elig;
  logic [N-1:0]                 nz;

  // request decode
  logic          accept;
  logic          load_ok;
  logic [SW-1:0] load_idx;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_idx = SW'(slot);
  assign load_ok  = (32'(slot) < N);

  // shared compare unit: one slot per cycle
  logic [psched_pkg::DUR_W-1:0]  cur_rem;
  logic [psched_pkg::PRI_W-1:0]  cur_pri;
  logic [psched_pkg::DUR_W-1:0]  cur_dur;
  logic [psched_pkg::TICK_W-1:0] cur_arr;
  logic                          cur_elig;
  logic                          cur_better;

  always_comb begin
    cur_rem    = slot_remaining[scan_idx];
    cur_pri    = slot_priority[scan_idx];
    cur_dur    = slot_duration[scan_idx];
    cur_arr    = slot_arrival[scan_idx];
    cur_elig   = (cur_arr <= elapsed_ticks) && (cur_rem != '0);
    cur_better = !found || (cur_pri < best_pri) ||
                 ((cur_pri == best_pri) && (cur_dur < best_dur));
  end

  // update step
  logic [N-1:0]                 best_oh;
  logic [psched_pkg::DUR_W-1:0] left;
  logic                         done;
  logic                         out_free;

  always_comb begin
    best_oh = found ? (N'(1) << best_idx) : '0;
    left    = found ? (slot_remaining[best_idx] - 1'b1) : '0;
    done    = (left == '0) && ((nz & ~best_oh) == '0);
    out_free = !(out_valid && out_stall);
  end

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      elapsed_ticks <= '0;
      out_valid     <= 1'b0;
      scan_idx      <= '0;
      found         <= 1'b0;
      for (int i = 0; i < N; i++) begin
        slot_remaining[i] <= '0;
      end
    end else begin
      // the update step sets out_valid itself
      if (out_valid && !out_stall && state != ST_UPDATE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (operation == psched_pkg::OP_LOAD) begin
              if (load_ok) begin
                slot_remaining[load_idx] <= duration;
              end
            end else begin
              if (elapsed_ticks != psched_pkg::TICK_MAX) begin
                elapsed_ticks <= elapsed_ticks + 1'b1;
              end
              scan_idx <= '0;
              found    <= 1'b0;
              state    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (cur_elig && cur_better) begin
            found <= 1'b1;
          end
          if (scan_idx == SW'(N - 1)) begin
            state <= ST_UPDATE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_UPDATE: begin
          // hold until the result register is free
          if (out_free) begin
            if (found) begin
              slot_remaining[best_idx] <= left;
            end
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers: slot fields, scan winners, result
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && operation == psched_pkg::OP_LOAD && load_ok) begin
      slot_duration[load_idx] <= duration;
      slot_priority[load_idx] <= priority_req;
      slot_arrival[load_idx]  <= arrival;
    end
    if (state == ST_SCAN) begin
      if (cur_elig && cur_better) begin
        best_idx <= scan_idx;
        best_pri <= cur_pri;
        best_dur <= cur_dur;
      end
      elig[scan_idx] <= cur_elig;
      nz[scan_idx]   <= (cur_rem != '0);
    end
    if (state == ST_UPDATE && out_free) begin
      tick_now       <= elapsed_ticks;
      running_slot   <= found ? 2'(best_idx) : 2'd0;
      idle           <= !found;
      waiting_mask   <= 3'(elig & ~best_oh);
      remaining_left <= left;
      all_done       <= done;
    end
  end

  // checks
  a_best_eligible: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && found) |-> elig[best_idx])
    else $error("chosen slot was not eligible");

  a_elig_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> ((elig & ~nz) == '0))
    else $error("eligible slot without remaining work");

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && idle) |-> (running_slot == 2'd0 && remaining_left == '0 &&
                             waiting_mask == 3'd0))
    else $error("idle result carries a running slot or waiting slots");

  a_run_not_waiting: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !idle) |-> (((3'd1 << running_slot) & waiting_mask) == 3'd0))
    else $error("running slot also marked waiting");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && out_valid && out_stall) |=> (state == ST_UPDATE))
    else $error("tick finished while result register was full");

endmodule
